// ----- hdl/ttou_pkg.sv -----
// shared types and constants for the text to unsigned parser
`default_nettype none

package ttou_pkg;

   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_WIDTH = 2;

   localparam logic [5:0] BASE_MAX = 6'd36;
   localparam logic [5:0] BASE_HEX = 6'd16;
   localparam logic [5:0] BASE_OCT = 6'd8;
   localparam logic [5:0] BASE_DEC = 6'd10;
   localparam logic [5:0] NO_DIGIT = 6'h3F;

   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_LOW_A  = 8'h61;
   localparam logic [7:0] CHAR_LOW_Z  = 8'h7A;
   localparam logic [7:0] CHAR_UP_A   = 8'h41;
   localparam logic [7:0] CHAR_UP_Z   = 8'h5A;
   localparam logic [7:0] CHAR_LOW_X  = 8'h78;
   localparam logic [7:0] CHAR_UP_X   = 8'h58;
   localparam logic [7:0] DIGIT_ALPHA = 8'd10;

   typedef enum logic [1:0] {
      PH_WS     = 2'd0,
      PH_PREFIX = 2'd1,
      PH_ZERO   = 2'd2,
      PH_DIGITS = 2'd3
   } phase_type;

   typedef struct packed {
      logic       start;
      logic [5:0] base;
      logic [5:0] digit;
      logic       is_space;
      logic       is_plus;
      logic       is_zero;
      logic       is_dec;
      logic       is_x;
   } entry_type;

endpackage

`default_nettype wire

// ----- hdl/text_to_unsigned_parser_unit.sv -----
// top level of the streaming text to unsigned number parser
`default_nettype none

// Parses one character per transaction at a sustained one character per clock while
// the result side does not stall. A character is classified on entry and placed in a
// four-entry queue; the parse engine takes one entry per cycle unless a result waits
// unaccepted, and does one multiply-add of the accumulator by the base (at most 36)
// per digit, which sets the cycle time. The character that ends a parse passes the
// queue, and its result is then held in an output register; while it waits, the queue
// takes characters until full. The base register may be written only while idle.
module text_to_unsigned_parser_unit #(
   parameter int VALUE_WIDTH  = 32,
   parameter int OFFSET_WIDTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [5:0]  csr_data,      // base_select
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,     // char_code
   input  wire logic        req_tuser,     // start_of_string
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [((VALUE_WIDTH+OFFSET_WIDTH+7)/8)*8-1:0] rsp_tdata, // parsed_value, stop_offset
   output logic [1:0]       rsp_tuser      // overflow_flag, no_base_flag
);

   localparam int RSP_DATA_WIDTH = ((VALUE_WIDTH + OFFSET_WIDTH + 7) / 8) * 8;

   ttou_pkg::entry_type       front_entry;
   ttou_pkg::entry_type       back_entry;
   logic                      entry_valid;
   logic                      entry_pop;
   logic [VALUE_WIDTH-1:0]    parsed_value;
   logic [OFFSET_WIDTH-1:0]   stop_offset;
   logic                      overflow_flag;
   logic                      no_base_flag;

   ttou_front u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .char_code       (req_tdata),
      .start_of_string (req_tuser),
      .entry           (front_entry)
   );

   ttou_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid),
      .push_ready (req_tready),
      .push_entry (front_entry),
      .pop_valid  (entry_valid),
      .pop        (entry_pop),
      .pop_entry  (back_entry)
   );

   ttou_back #(
      .VALUE_WIDTH  (VALUE_WIDTH),
      .OFFSET_WIDTH (OFFSET_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .entry_valid   (entry_valid),
      .entry_pop     (entry_pop),
      .entry         (back_entry),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .parsed_value  (parsed_value),
      .stop_offset   (stop_offset),
      .overflow_flag (overflow_flag),
      .no_base_flag  (no_base_flag)
   );

   assign rsp_tdata = RSP_DATA_WIDTH'({stop_offset, parsed_value});
   assign rsp_tuser = {no_base_flag, overflow_flag};

endmodule

`default_nettype wire

// ----- hdl/ttou_front.sv -----
// front end: base register, character classification into queue entries
`default_nettype none

module ttou_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [5:0]        csr_data,
   input  wire logic [7:0]        char_code,
   input  wire logic              start_of_string,
   output ttou_pkg::entry_type    entry
);

   logic [5:0] base_select_ff;
   logic [5:0] base_select_in;
   logic [7:0] dec_off;
   logic [7:0] low_off;
   logic [7:0] up_off;

   assign csr_ready = 1'b1;

   always_comb begin
      base_select_in = base_select_ff;
      if (csr_valid) begin
         base_select_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_select_ff <= '0;
      end else begin
         base_select_ff <= base_select_in;
      end
   end

   always_comb begin
      dec_off = char_code - ttou_pkg::CHAR_ZERO;
      low_off = char_code - ttou_pkg::CHAR_LOW_A + ttou_pkg::DIGIT_ALPHA;
      up_off  = char_code - ttou_pkg::CHAR_UP_A + ttou_pkg::DIGIT_ALPHA;

      entry.start    = start_of_string;
      entry.base     = (base_select_ff > ttou_pkg::BASE_MAX) ? ttou_pkg::BASE_MAX
                                                              : base_select_ff;
      entry.is_space = (char_code == ttou_pkg::CHAR_SPACE) ||
                       ((char_code >= ttou_pkg::CHAR_TAB) && (char_code <= ttou_pkg::CHAR_CR));
      entry.is_plus  = (char_code == ttou_pkg::CHAR_PLUS);
      entry.is_zero  = (char_code == ttou_pkg::CHAR_ZERO);
      entry.is_dec   = (char_code >= ttou_pkg::CHAR_ZERO) && (char_code <= ttou_pkg::CHAR_NINE);
      entry.is_x     = (char_code == ttou_pkg::CHAR_LOW_X) || (char_code == ttou_pkg::CHAR_UP_X);

      if (entry.is_dec) begin
         entry.digit = dec_off[5:0];
      end else if ((char_code >= ttou_pkg::CHAR_LOW_A) && (char_code <= ttou_pkg::CHAR_LOW_Z)) begin
         entry.digit = low_off[5:0];
      end else if ((char_code >= ttou_pkg::CHAR_UP_A) && (char_code <= ttou_pkg::CHAR_UP_Z)) begin
         entry.digit = up_off[5:0];
      end else begin
         entry.digit = ttou_pkg::NO_DIGIT;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/ttou_queue.sv -----
// short queue of classified characters between front and back end
`default_nettype none

module ttou_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   output logic                   push_ready,
   input  wire ttou_pkg::entry_type push_entry,
   output logic                   pop_valid,
   input  wire logic              pop,
   output ttou_pkg::entry_type    pop_entry
);

   ttou_pkg::entry_type                   slot_ff [ttou_pkg::QUEUE_DEPTH];
   logic [ttou_pkg::QUEUE_PTR_WIDTH-1:0]  wr_ptr_ff;
   logic [ttou_pkg::QUEUE_PTR_WIDTH-1:0]  wr_ptr_in;
   logic [ttou_pkg::QUEUE_PTR_WIDTH-1:0]  rd_ptr_ff;
   logic [ttou_pkg::QUEUE_PTR_WIDTH-1:0]  rd_ptr_in;
   logic [ttou_pkg::QUEUE_PTR_WIDTH:0]    count_ff;
   logic [ttou_pkg::QUEUE_PTR_WIDTH:0]    count_in;
   logic                                  do_push;
   logic                                  do_pop;

   assign push_ready = (count_ff != (ttou_pkg::QUEUE_PTR_WIDTH+1)'(ttou_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/ttou_back.sv -----
// back end: parse state machine, multiply-add accumulator and result register
`default_nettype none

module ttou_back #(
   parameter int VALUE_WIDTH  = 32,
   parameter int OFFSET_WIDTH = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    entry_valid,
   output logic                         entry_pop,
   input  wire ttou_pkg::entry_type     entry,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [VALUE_WIDTH-1:0]       parsed_value,
   output logic [OFFSET_WIDTH-1:0]      stop_offset,
   output logic                         overflow_flag,
   output logic                         no_base_flag
);

   localparam int WIDE_WIDTH = VALUE_WIDTH + 6;

   ttou_pkg::phase_type        phase_ff, phase_in, cur_phase;
   logic [VALUE_WIDTH-1:0]     acc_ff, acc_in, cur_acc;
   logic [OFFSET_WIDTH-1:0]    pos_ff, pos_in, cur_pos, pos_next;
   logic [5:0]                 base_ff, base_in, cur_base, dig_base;
   logic                       fin_ff, fin_in, cur_fin;
   logic                       take;
   logic                       prefix_go;
   logic                       digit_go;
   logic                       emit;
   logic [VALUE_WIDTH-1:0]     emit_value;
   logic                       emit_ovf;
   logic                       emit_nob;
   logic [WIDE_WIDTH-1:0]      wide;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0]     value_ff;
   logic [OFFSET_WIDTH-1:0]    offset_ff;
   logic                       ovf_ff;
   logic                       nob_ff;

   assign take      = entry_valid && (!rsp_valid_ff || rsp_ready);
   assign entry_pop = take;

   always_comb begin
      cur_phase = entry.start ? ttou_pkg::PH_WS : phase_ff;
      cur_acc   = entry.start ? '0 : acc_ff;
      cur_pos   = entry.start ? '0 : pos_ff;
      cur_base  = entry.start ? entry.base : base_ff;
      cur_fin   = entry.start ? 1'b0 : fin_ff;
      pos_next  = (cur_pos == {OFFSET_WIDTH{1'b1}}) ? cur_pos : cur_pos + 1'b1;

      phase_in   = cur_phase;
      acc_in     = cur_acc;
      pos_in     = cur_pos;
      base_in    = cur_base;
      fin_in     = cur_fin;
      prefix_go  = 1'b0;
      digit_go   = 1'b0;
      dig_base   = cur_base;
      emit       = 1'b0;
      emit_value = '0;
      emit_ovf   = 1'b0;
      emit_nob   = 1'b0;

      if (!cur_fin) begin
         unique case (cur_phase)
            ttou_pkg::PH_WS: begin
               if (entry.is_space) begin
                  pos_in = pos_next;
               end else if (entry.is_plus) begin
                  phase_in = ttou_pkg::PH_PREFIX;
                  pos_in   = pos_next;
               end else begin
                  prefix_go = 1'b1;
               end
            end
            ttou_pkg::PH_PREFIX: begin
               prefix_go = 1'b1;
            end
            ttou_pkg::PH_ZERO: begin
               if (entry.is_x) begin
                  base_in  = ttou_pkg::BASE_HEX;
                  phase_in = ttou_pkg::PH_DIGITS;
                  pos_in   = pos_next;
               end else if (entry.is_dec) begin
                  dig_base = ttou_pkg::BASE_OCT;
                  digit_go = 1'b1;
               end else begin
                  emit     = 1'b1;
                  emit_nob = 1'b1;
               end
            end
            ttou_pkg::PH_DIGITS: begin
               digit_go = 1'b1;
            end
            default: begin
               digit_go = 1'b1;
            end
         endcase

         if (prefix_go) begin
            if (cur_base != '0) begin
               digit_go = 1'b1;
            end else if (entry.is_zero) begin
               phase_in = ttou_pkg::PH_ZERO;
               pos_in   = pos_next;
            end else if (entry.is_dec) begin
               dig_base = ttou_pkg::BASE_DEC;
               digit_go = 1'b1;
            end else begin
               emit     = 1'b1;
               emit_nob = 1'b1;
            end
         end
      end

      wide = WIDE_WIDTH'(cur_acc) * WIDE_WIDTH'(dig_base) + WIDE_WIDTH'(entry.digit);

      if (digit_go) begin
         phase_in = ttou_pkg::PH_DIGITS;
         base_in  = dig_base;
         if ((dig_base == '0) || (entry.digit >= dig_base)) begin
            emit       = 1'b1;
            emit_value = cur_acc;
         end else if (wide[WIDE_WIDTH-1:VALUE_WIDTH] != '0) begin
            emit     = 1'b1;
            emit_ovf = 1'b1;
         end else begin
            acc_in = wide[VALUE_WIDTH-1:0];
            pos_in = pos_next;
         end
      end

      if (emit) begin
         fin_in = 1'b1;
      end

      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (take && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= ttou_pkg::PH_WS;
         acc_ff       <= '0;
         pos_ff       <= '0;
         base_ff      <= '0;
         fin_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            phase_ff <= phase_in;
            acc_ff   <= acc_in;
            pos_ff   <= pos_in;
            base_ff  <= base_in;
            fin_ff   <= fin_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && emit) begin
         value_ff  <= emit_value;
         offset_ff <= cur_pos;
         ovf_ff    <= emit_ovf;
         nob_ff    <= emit_nob;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign parsed_value  = value_ff;
   assign stop_offset   = offset_ff;
   assign overflow_flag = ovf_ff;
   assign no_base_flag  = nob_ff;

endmodule

`default_nettype wire

// ----- hdl/ttou_checker.sv -----
// port-level checks for the text to unsigned parser
`default_nettype none

module ttou_checker #(
   parameter int VALUE_WIDTH  = 32,
   parameter int OFFSET_WIDTH = 16
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_tvalid,
   input wire logic rsp_tready,
   input wire logic [((VALUE_WIDTH+OFFSET_WIDTH+7)/8)*8-1:0] rsp_tdata,
   input wire logic [1:0] rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("overflow and no base both set");

   a_flag_zero_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[0] || rsp_tuser[1]) |-> rsp_tdata[VALUE_WIDTH-1:0] == '0)
      else $error("nonzero value with error flag");

endmodule

bind text_to_unsigned_parser_unit ttou_checker #(
   .VALUE_WIDTH  (VALUE_WIDTH),
   .OFFSET_WIDTH (OFFSET_WIDTH)
) u_ttou_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// ----- tb/ttou_result_checker.sv -----
// checker that predicts parser results from the observed transactions and compares them
`default_nettype none

module ttou_result_checker
   import ttou_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [5:0]  csr_data,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [7:0]  req_tdata,     // char_code
   input  wire logic        req_tuser,     // start_of_string
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [47:0] rsp_tdata,     // parsed_value, stop_offset
   input  wire logic [1:0]  rsp_tuser,     // overflow_flag, no_base_flag
   output int               failures,
   output int               pending,
   output int               results_seen,
   output int               overflows_seen,
   output int               no_base_seen
);

   typedef struct packed {
      logic [31:0] value;
      logic [15:0] offset;
      logic        overflow;
      logic        no_base;
   } parse_result_type;

   parse_result_type predicted_parses[$];

   logic [5:0]  base_reg;
   logic [5:0]  cur_base;
   phase_type   phase;
   logic [31:0] acc;
   logic [15:0] pos;
   bit          done;

   function automatic bit is_dec(input logic [7:0] c);
      return c >= CHAR_ZERO && c <= CHAR_NINE;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (failures < 20)
         $display("mismatch at result %0d: %s got %0h expected %0h",
                  results_seen, what, got, want);
      failures++;
   endtask

   task automatic bump_pos();
      if (pos != '1) pos = pos + 16'd1;
   endtask

   task automatic close_parse(input logic [31:0] value, input logic ovf, input logic nob);
      parse_result_type r;
      r.value    = value;
      r.offset   = pos;
      r.overflow = ovf;
      r.no_base  = nob;
      predicted_parses.push_back(r);
      done = 1'b1;
   endtask

   task automatic take_digit(input logic [7:0] c);
      int unsigned d;
      if (is_dec(c)) d = c - CHAR_ZERO;
      else if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) d = c - CHAR_LOW_A + DIGIT_ALPHA;
      else if (c >= CHAR_UP_A && c <= CHAR_UP_Z) d = c - CHAR_UP_A + DIGIT_ALPHA;
      else d = 255;
      phase = PH_DIGITS;
      if (cur_base == 6'd0 || d >= cur_base)
         close_parse(acc, 1'b0, 1'b0);
      else if (64'(acc) > (64'hFFFF_FFFF - 64'(d)) / 64'(cur_base))
         close_parse('0, 1'b1, 1'b0);
      else begin
         acc = acc * 32'(cur_base) + d;
         bump_pos();
      end
   endtask

   task automatic take_lead(input logic [7:0] c);
      if (cur_base != 6'd0) take_digit(c);
      else if (c == CHAR_ZERO) begin
         phase = PH_ZERO;
         bump_pos();
      end else if (is_dec(c)) begin
         cur_base = BASE_DEC;
         take_digit(c);
      end else close_parse('0, 1'b0, 1'b1);
   endtask

   task automatic parse_char(input logic [7:0] c, input logic start);
      if (start) begin
         phase    = PH_WS;
         acc      = '0;
         pos      = '0;
         cur_base = base_reg > BASE_MAX ? BASE_MAX : base_reg;
         done     = 1'b0;
      end
      if (!done) begin
         case (phase)
            PH_WS: begin
               if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) bump_pos();
               else if (c == CHAR_PLUS) begin
                  phase = PH_PREFIX;
                  bump_pos();
               end else take_lead(c);
            end
            PH_PREFIX: take_lead(c);
            PH_ZERO: begin
               if (c == CHAR_LOW_X || c == CHAR_UP_X) begin
                  cur_base = BASE_HEX;
                  phase    = PH_DIGITS;
                  bump_pos();
               end else if (is_dec(c)) begin
                  cur_base = BASE_OCT;
                  take_digit(c);
               end else close_parse('0, 1'b0, 1'b1);
            end
            default: take_digit(c);
         endcase
      end
   endtask

   always @(posedge clock) begin
      parse_result_type want;
      if (reset) begin
         base_reg       = '0;
         cur_base       = '0;
         phase          = PH_WS;
         acc            = '0;
         pos            = '0;
         done           = 1'b1;
         failures       = 0;
         results_seen   = 0;
         overflows_seen = 0;
         no_base_seen   = 0;
         predicted_parses.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (rsp_tuser[0]) overflows_seen++;
            if (rsp_tuser[1]) no_base_seen++;
            if (predicted_parses.size() == 0)
               report_mismatch("transaction with no result pending", 64'(rsp_tdata), '0);
            else begin
               want = predicted_parses.pop_front();
               if (rsp_tdata[31:0] !== want.value)
                  report_mismatch("parsed_value", 64'(rsp_tdata[31:0]), 64'(want.value));
               if (rsp_tdata[47:32] !== want.offset)
                  report_mismatch("stop_offset", 64'(rsp_tdata[47:32]), 64'(want.offset));
               if (rsp_tuser[0] !== want.overflow)
                  report_mismatch("overflow_flag", 64'(rsp_tuser[0]), 64'(want.overflow));
               if (rsp_tuser[1] !== want.no_base)
                  report_mismatch("no_base_flag", 64'(rsp_tuser[1]), 64'(want.no_base));
            end
         end
         if (csr_valid && csr_ready) base_reg = csr_data;
         if (req_tvalid && req_tready) parse_char(req_tdata, req_tuser);
      end
      pending = predicted_parses.size();
   end

endmodule

`default_nettype wire

// ----- tb/text_to_unsigned_parser_unit_test.sv -----
// testbench top for the text to unsigned parser: stimulus, handshakes and verdict
`default_nettype none

module text_to_unsigned_parser_unit_test;
   import ttou_pkg::*;

   localparam int         CYCLE_LIMIT  = 600000;
   localparam int         PHASE_ITEMS  = 200;
   localparam int         SETTLE_TIME  = 16;
   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam int         BASE_PLAN[10] = '{10, 16, 0, 8, 2, 36, 63, 1, 37, 0};

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [5:0]  csr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;     // char_code
   logic        req_tuser;     // start_of_string
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;     // parsed_value, stop_offset
   logic [1:0]  rsp_tuser;     // overflow_flag, no_base_flag

   int failures;
   int pending;
   int results_seen;
   int overflows_seen;
   int no_base_seen;

   int         cycles        = 0;
   int         strings_sent  = 0;
   int         items_sent    = 0;
   int         base_now      = 0;
   bit         send_gaps     = 1'b1;
   bit         recv_stalls   = 1'b1;
   logic [7:0] text_buf[$];

   text_to_unsigned_parser_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   ttou_result_checker results_check (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .failures       (failures),
      .pending        (pending),
      .results_seen   (results_seen),
      .overflows_seen (overflows_seen),
      .no_base_seen   (no_base_seen)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("** text_to_unsigned_parser_unit: FAILED **");
         $finish;
      end
   end

   // result side back-pressure
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (recv_stalls && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_char(input logic [7:0] c, input logic start);
      if (send_gaps && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tuser  <= start;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_text();
      foreach (text_buf[i]) send_char(text_buf[i], i == 0);
      items_sent += text_buf.size();
      strings_sent++;
   endtask

   // wait for every pending result, then let the pipeline drain
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_TIME) @(negedge clock);
   endtask

   task automatic write_base(input int b);
      settle();
      base_now  = b;
      csr_valid <= 1'b1;
      csr_data  <= 6'(b);
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic push_digit(input int unsigned d);
      if (d < 10) text_buf.push_back(8'(CHAR_ZERO + d));
      else text_buf.push_back(8'(($urandom_range(0, 1) ? CHAR_LOW_A : CHAR_UP_A) + d
                                 - DIGIT_ALPHA));
   endtask

   task automatic push_number(input longint unsigned v, input int eb);
      int unsigned digits[$];
      if (eb < 2) repeat ($urandom_range(1, 5)) push_digit(0);
      else begin
         do begin
            digits.push_front(32'(v % longint'(eb)));
            v = v / longint'(eb);
         end while (v != 0);
         foreach (digits[i]) push_digit(digits[i]);
      end
   endtask

   task automatic make_string();
      int eb;
      int pick;
      longint unsigned v;
      text_buf.delete();
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3))
            text_buf.push_back($urandom_range(0, 5) == 0 ? CHAR_SPACE
                               : 8'($urandom_range(CHAR_TAB, CHAR_CR)));
      if ($urandom_range(0, 4) == 0) text_buf.push_back(CHAR_PLUS);
      eb = base_now > BASE_MAX ? BASE_MAX : base_now;
      if (base_now == 0) begin
         pick = $urandom_range(0, 9);
         if (pick < 3) begin
            text_buf.push_back(CHAR_ZERO);
            text_buf.push_back(pick == 0 ? CHAR_UP_X : CHAR_LOW_X);
            eb = BASE_HEX;
         end else if (pick < 5) begin
            text_buf.push_back(CHAR_ZERO);
            eb = BASE_OCT;
         end else if (pick < 8) eb = BASE_DEC;
         else if (pick == 8) begin
            text_buf.push_back(8'(CHAR_LOW_A + $urandom_range(0, 25)));
            eb = 0;
         end else begin
            text_buf.push_back(CHAR_ZERO);
            text_buf.push_back($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
            eb = 0;
         end
      end else if ($urandom_range(0, 9) == 0) begin
         // hex prefix is not special with an explicit base
         text_buf.push_back(CHAR_ZERO);
         text_buf.push_back(CHAR_LOW_X);
      end
      if (eb != 0) begin
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            case ($urandom_range(0, 3))
               0: v = 64'hFFFF_FFFF;
               1: v = 64'h1_0000_0000;
               2: v = 64'hFFFF_FFFF - $urandom_range(0, 40);
               default: v = 64'h1_0000_0000 + $urandom_range(0, 40);
            endcase
            push_number(v, eb);
         end else if (pick == 1) repeat (40) push_digit($urandom_range(0, eb - 1));
         else begin
            repeat ($urandom_range(0, 8)) begin
               if ($urandom_range(0, 9) == 0) push_digit($urandom_range(0, 35));
               else push_digit($urandom_range(0, eb - 1));
            end
         end
      end
      pick = $urandom_range(0, 9);
      if (pick < 5) text_buf.push_back(CHAR_NUL);
      else if (pick < 8) text_buf.push_back(8'($urandom_range(0, 255)));
      if (text_buf.size() == 0) text_buf.push_back(CHAR_NUL);
      send_text();
      // trailing characters after the result are ignored
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(0, 255)), 1'b0);
   endtask

   initial begin
      int phase_start;
      reset      = 1'b1;
      csr_valid  = 1'b0;
      csr_data   = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed strings with the reset base
      send_char(CHAR_UP_A, 1'b0);
      text_buf.delete();
      for (int k = CHAR_TAB; k <= CHAR_CR; k++) text_buf.push_back(8'(k));
      text_buf.push_back(CHAR_SPACE);
      text_buf.push_back(CHAR_PLUS);
      text_buf.push_back(CHAR_ZERO);
      text_buf.push_back(CHAR_UP_X);
      text_buf.push_back(8'(CHAR_LOW_A + 5));
      text_buf.push_back(CHAR_UP_Z);
      send_text();
      text_buf = {CHAR_ZERO, 8'(CHAR_ZERO + 7), 8'(CHAR_ZERO + 8)};
      send_text();
      text_buf = {CHAR_ZERO, 8'(CHAR_LOW_A + 16)};
      send_text();
      text_buf = {CHAR_MINUS};
      send_text();
      send_char(8'(CHAR_ZERO + 5), 1'b1);
      send_char(8'(CHAR_ZERO + 3), 1'b0);
      send_char(CHAR_NINE, 1'b1);
      send_char(CHAR_NUL, 1'b0);
      send_char(CHAR_UP_A, 1'b0);
      send_char(8'hFF, 1'b1);

      for (int p = 0; p < 10; p++) begin
         write_base(BASE_PLAN[p]);
         if (p == 9) begin
            send_gaps   = 1'b0;
            recv_stalls = 1'b0;
         end
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            if (p != 9 && strings_sent % 16 == 0) begin
               send_gaps   = $urandom_range(0, 3) != 0;
               recv_stalls = $urandom_range(0, 3) != 0;
            end
            if ($urandom_range(0, 11) == 0)
               send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            else make_string();
         end
      end

      settle();
      $display("sent %0d strings, %0d characters, over %0d base settings",
               strings_sent, items_sent, 10);
      $display("checked %0d results: %0d overflows, %0d without a base",
               results_seen, overflows_seen, no_base_seen);
      if (failures == 0 && pending == 0)
         $display("** text_to_unsigned_parser_unit: PASSED **");
      else
         $display("** text_to_unsigned_parser_unit: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire

// ----- files.f -----
hdl/ttou_pkg.sv
hdl/ttou_front.sv
hdl/ttou_queue.sv
hdl/ttou_back.sv
hdl/text_to_unsigned_parser_unit.sv
hdl/ttou_checker.sv
tb/ttou_result_checker.sv
tb/text_to_unsigned_parser_unit_test.sv
